@@ src/brag_pkg.sv @@
// shared types and constants of the block row address generator
package brag_pkg;

  localparam int unsigned MAX_BLOCK_ROWS_DEF = 64;
  localparam int unsigned MAX_ELEM_BYTES     = 8;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_MATRIX_ROWS   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MATRIX_COLS   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_ROWS    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COLS    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RANK_NUMBER   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ELEMENT_BYTES = 3'd5;

  localparam int unsigned ROW_LEN_W = 19;
  localparam int unsigned STATUS_W  = 2;

  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_ROW_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_COL_RANGE = 2'd2;

  typedef struct packed {
    logic [15:0] matrix_rows;
    logic [15:0] matrix_cols;
    logic [6:0]  block_rows;
    logic [15:0] block_cols;
    logic [15:0] rank_number;
    logic [3:0]  element_bytes;
  } cfg_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic err_latch;
    logic addr_load;
    logic addr_step;
    logic show_err;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic row_fail;
    logic col_fail;
    logic no_rows;
    logic last;
  } sts_t;

endpackage

@@ src/brag_if.sv @@
// handshake interfaces for input items and descriptors
interface brag_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] block_row_index;
  logic [15:0] block_col_index;
  logic [63:0] first_base;
  logic [63:0] second_base;

  modport source (output valid, block_row_index, block_col_index, first_base, second_base,
                  input ready);
  modport sink (input valid, block_row_index, block_col_index, first_base, second_base,
                output ready);
endinterface

interface brag_out_if;
  logic                          valid;
  logic                          ready;
  logic [15:0]                   rank_out;
  logic [63:0]                   first_address;
  logic [63:0]                   second_address;
  logic [brag_pkg::ROW_LEN_W-1:0] row_length_bytes;
  logic                          last_row;
  logic [brag_pkg::STATUS_W-1:0] status;

  modport source (output valid, rank_out, first_address, second_address, row_length_bytes,
                  last_row, status, input ready);
  modport sink (input valid, rank_out, first_address, second_address, row_length_bytes,
                last_row, status, output ready);
endinterface

@@ src/brag_cfg.sv @@
// configuration register file
module brag_cfg (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [brag_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [brag_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output brag_pkg::cfg_t                  cfg_o
);

  brag_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        brag_pkg::CFG_MATRIX_ROWS:   cfg_d.matrix_rows   = cfg_data_i;
        brag_pkg::CFG_MATRIX_COLS:   cfg_d.matrix_cols   = cfg_data_i;
        brag_pkg::CFG_BLOCK_ROWS:    cfg_d.block_rows    = cfg_data_i[6:0];
        brag_pkg::CFG_BLOCK_COLS:    cfg_d.block_cols    = cfg_data_i;
        brag_pkg::CFG_RANK_NUMBER:   cfg_d.rank_number   = cfg_data_i;
        brag_pkg::CFG_ELEMENT_BYTES: cfg_d.element_bytes = cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.matrix_rows   <= 16'd1;
      cfg_q.matrix_cols   <= 16'd1;
      cfg_q.block_rows    <= 7'd1;
      cfg_q.block_cols    <= 16'd1;
      cfg_q.rank_number   <= 16'd0;
      cfg_q.element_bytes <= 4'd1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ src/brag_ctrl.sv @@
// sequencing state machine
module brag_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  brag_pkg::sts_t     sts_i,
  output brag_pkg::cmd_t     cmd_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_CHK  = 3'd2;
  localparam logic [2:0] S_SUM  = 3'd3;
  localparam logic [2:0] S_SCL  = 3'd4;
  localparam logic [2:0] S_BASE = 3'd5;
  localparam logic [2:0] S_EMIT = 3'd6;
  localparam logic [2:0] S_ERR  = 3'd7;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_MUL;
        end
      end
      S_MUL: state_d = S_CHK;
      S_CHK: begin
        if (sts_i.row_fail || sts_i.col_fail) begin
          cmd_o.err_latch = 1'b1;
          state_d         = S_ERR;
        end else if (sts_i.no_rows) begin
          state_d = S_IDLE;
        end else begin
          state_d = S_SUM;
        end
      end
      S_SUM: state_d = S_SCL;
      S_SCL: state_d = S_BASE;
      S_BASE: begin
        cmd_o.addr_load = 1'b1;
        state_d         = S_EMIT;
      end
      S_EMIT: begin
        if (out_ready_i) begin
          cmd_o.addr_step = 1'b1;
          if (sts_i.last) begin
            state_d = S_IDLE;
          end
        end
      end
      S_ERR: begin
        cmd_o.show_err = 1'b1;
        if (out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_EMIT) || (state_q == S_ERR);

endmodule

@@ src/brag_dp.sv @@
// scaling, bounds check and address stepping
module brag_dp #(
  parameter int unsigned MAX_BLOCK_ROWS = brag_pkg::MAX_BLOCK_ROWS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  brag_pkg::cfg_t                 cfg_i,
  input  brag_pkg::cmd_t                 cmd_i,
  output brag_pkg::sts_t                 sts_o,
  input  logic [15:0]                    block_row_index_i,
  input  logic [15:0]                    block_col_index_i,
  input  logic [63:0]                    first_base_i,
  input  logic [63:0]                    second_base_i,
  output logic [15:0]                    rank_out_o,
  output logic [63:0]                    first_address_o,
  output logic [63:0]                    second_address_o,
  output logic [brag_pkg::ROW_LEN_W-1:0] row_length_bytes_o,
  output logic                           last_row_o,
  output logic [brag_pkg::STATUS_W-1:0]  status_o
);

  localparam int unsigned CntW  = $clog2(MAX_BLOCK_ROWS + 1);
  localparam int unsigned RowW  = 16 + CntW;
  localparam int unsigned ProdW = 16 + RowW;
  localparam int unsigned LinW  = ProdW + 1;
  localparam int unsigned OffW  = LinW + 4;
  localparam logic [6:0]  MaxRows7 = 7'(MAX_BLOCK_ROWS);

  logic [15:0]      brow_q, bcol_q;
  logic [63:0]      base_a_q, base_b_q;
  logic [CntW-1:0]  nrows_q, nrows_d;
  logic [3:0]       eb_q, eb_d;
  logic [RowW-1:0]  row0_q;
  logic [31:0]      col0_q;
  logic [ProdW-1:0] prod_q;
  logic [LinW-1:0]  lin_q;
  logic [OffW-1:0]  off_q;
  logic [19:0]      pitch_q;
  logic [19:0]      row_len_full;
  logic [brag_pkg::ROW_LEN_W-1:0] row_len_q;
  logic [63:0]      addr_a_q, addr_b_q;
  logic [CntW-1:0]  cnt_q;
  logic [brag_pkg::STATUS_W-1:0] err_q;

  // saturate row count and element size at capture
  always_comb begin
    nrows_d = (cfg_i.block_rows > MaxRows7) ? CntW'(MAX_BLOCK_ROWS) : CntW'(cfg_i.block_rows);
    eb_d    = (cfg_i.element_bytes > 4'(brag_pkg::MAX_ELEM_BYTES)) ?
              4'(brag_pkg::MAX_ELEM_BYTES) : cfg_i.element_bytes;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      brow_q   <= block_row_index_i;
      bcol_q   <= block_col_index_i;
      base_a_q <= first_base_i;
      base_b_q <= second_base_i;
      nrows_q  <= nrows_d;
      eb_q     <= eb_d;
    end
  end

  assign row_len_full = 20'(cfg_i.block_cols) * 20'(eb_q);

  // free running offset chain, settled by the time the controller reaches the base step
  always_ff @(posedge clk_i) begin
    row0_q    <= RowW'(brow_q) * RowW'(nrows_q);
    col0_q    <= 32'(bcol_q) * 32'(cfg_i.block_cols);
    prod_q    <= ProdW'(cfg_i.matrix_cols) * ProdW'(row0_q);
    lin_q     <= LinW'(prod_q) + LinW'(col0_q);
    off_q     <= OffW'(lin_q) * OffW'(eb_q);
    pitch_q   <= 20'(cfg_i.matrix_cols) * 20'(eb_q);
    row_len_q <= row_len_full[brag_pkg::ROW_LEN_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.addr_load) begin
      addr_a_q <= base_a_q + 64'(off_q);
      addr_b_q <= base_b_q + 64'(off_q);
    end else if (cmd_i.addr_step) begin
      addr_a_q <= addr_a_q + 64'(pitch_q);
      addr_b_q <= addr_b_q + 64'(pitch_q);
    end
    if (cmd_i.err_latch) begin
      err_q <= sts_o.row_fail ? brag_pkg::STATUS_ROW_RANGE : brag_pkg::STATUS_COL_RANGE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.addr_load) begin
      cnt_q <= '0;
    end else if (cmd_i.addr_step) begin
      cnt_q <= cnt_q + 1'b1;
    end
  end

  assign sts_o.row_fail = (RowW'(cfg_i.matrix_rows) <= row0_q);
  assign sts_o.col_fail = (32'(cfg_i.matrix_cols) <= col0_q);
  assign sts_o.no_rows  = (nrows_q == '0);
  assign sts_o.last     = (cnt_q == nrows_q - 1'b1);

  always_comb begin
    if (cmd_i.show_err) begin
      rank_out_o         = '0;
      first_address_o    = '0;
      second_address_o   = '0;
      row_length_bytes_o = '0;
      last_row_o         = 1'b1;
      status_o           = err_q;
    end else begin
      rank_out_o         = cfg_i.rank_number;
      first_address_o    = addr_a_q;
      second_address_o   = addr_b_q;
      row_length_bytes_o = row_len_q;
      last_row_o         = sts_o.last;
      status_o           = brag_pkg::STATUS_OK;
    end
  end

endmodule

@@ src/block_row_address_generator_unit.sv @@
// block row address generator: one descriptor per block row of a requested block, or a single error descriptor
// sequence: after the input transaction the controller steps through multiply, check, sum, scale and base
//   states before the first descriptor; an error result is shown straight after the check state
// throughput: one descriptor per cycle while the output is ready, from the single address stepper
// input is taken only while no item is in work
// reset (async, active low) returns the controller to idle and the config registers and row counter to defaults
module block_row_address_generator_unit #(
  parameter int unsigned MAX_BLOCK_ROWS = brag_pkg::MAX_BLOCK_ROWS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  brag_in_if.sink                         in_if,
  brag_out_if.source                      out_if,
  input  logic                            cfg_we_i,
  input  logic [brag_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [brag_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  brag_pkg::cfg_t cfg;
  brag_pkg::cmd_t cmd;
  brag_pkg::sts_t sts;

  brag_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  brag_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_ready_o  (in_if.ready),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  brag_dp #(
    .MAX_BLOCK_ROWS (MAX_BLOCK_ROWS)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_i              (cfg),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .block_row_index_i  (in_if.block_row_index),
    .block_col_index_i  (in_if.block_col_index),
    .first_base_i       (in_if.first_base),
    .second_base_i      (in_if.second_base),
    .rank_out_o         (out_if.rank_out),
    .first_address_o    (out_if.first_address),
    .second_address_o   (out_if.second_address),
    .row_length_bytes_o (out_if.row_length_bytes),
    .last_row_o         (out_if.last_row),
    .status_o           (out_if.status)
  );

endmodule

@@ src/brag_checker.sv @@
// port level checks of the block row address generator
module brag_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_i,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic [15:0]                   rank_out_i,
  input logic [63:0]                   first_address_i,
  input logic                          last_row_i,
  input logic [brag_pkg::STATUS_W-1:0] status_i
);

  // one item at a time: no intake while results are shown
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_i && out_valid_i))
    else $error("input ready while a result is pending");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !out_valid_i)
    else $error("result right after an input transaction");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && status_i != brag_pkg::STATUS_OK) |->
      (last_row_i && rank_out_i == '0 && first_address_i == '0))
    else $error("error result not a lone zeroed descriptor");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(first_address_i)))
    else $error("stalled descriptor changed");

endmodule

bind block_row_address_generator_unit brag_checker u_brag_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_if.valid),
  .in_ready_i      (in_if.ready),
  .out_valid_i     (out_if.valid),
  .out_ready_i     (out_if.ready),
  .rank_out_i      (out_if.rank_out),
  .first_address_i (out_if.first_address),
  .last_row_i      (out_if.last_row),
  .status_i        (out_if.status)
);

@@ tb/block_row_address_generator_unit_test.sv @@
// self-checking testbench of the block row address generator unit
`timescale 1ns / 100ps

module block_row_address_generator_unit_test;

  localparam int unsigned DRAIN_CYCLES = 80;
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned IDLE_PCT     = 21;
  localparam int unsigned HOLD_CYCLES  = 400;

  // register indexes with no register behind them
  localparam logic [brag_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
  localparam logic [brag_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

  typedef struct packed {
    logic [15:0] brow;
    logic [15:0] bcol;
    logic [63:0] first_base;
    logic [63:0] second_base;
  } block_req_t;

  typedef struct packed {
    logic [15:0]                    rank;
    logic [63:0]                    first_addr;
    logic [63:0]                    second_addr;
    logic [brag_pkg::ROW_LEN_W-1:0] row_len;
    logic                           last;
    logic [brag_pkg::STATUS_W-1:0]  status;
  } row_desc_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic                            cfg_we_i;
  logic [brag_pkg::CFG_IDX_W-1:0]  cfg_idx_i;
  logic [brag_pkg::CFG_DATA_W-1:0] cfg_data_i;

  brag_in_if  req_ch ();
  brag_out_if desc_ch ();

  brag_pkg::cfg_t shadow_cfg;
  row_desc_t      expected_descs[$];
  int unsigned    errors;
  bit             no_idle;
  int unsigned    hold_requests;

  block_row_address_generator_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_if      (req_ch),
    .out_if     (desc_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // expected descriptors of one accepted block request
  function automatic void predict_rows(input block_req_t req);
    logic [63:0]                    nrows;
    logic [63:0]                    eb;
    logic [63:0]                    row0;
    logic [63:0]                    col0;
    logic [63:0]                    offset;
    logic [brag_pkg::ROW_LEN_W-1:0] row_len;
    row_desc_t                      d;
    nrows = (shadow_cfg.block_rows > brag_pkg::MAX_BLOCK_ROWS_DEF) ?
            64'(brag_pkg::MAX_BLOCK_ROWS_DEF) : 64'(shadow_cfg.block_rows);
    eb = (shadow_cfg.element_bytes > brag_pkg::MAX_ELEM_BYTES) ?
         64'(brag_pkg::MAX_ELEM_BYTES) : 64'(shadow_cfg.element_bytes);
    row0 = 64'(req.brow) * nrows;
    col0 = 64'(req.bcol) * 64'(shadow_cfg.block_cols);
    d = '0;
    d.last = 1'b1;
    if (row0 >= 64'(shadow_cfg.matrix_rows)) begin
      d.status = brag_pkg::STATUS_ROW_RANGE;
      expected_descs.push_back(d);
    end else if (col0 >= 64'(shadow_cfg.matrix_cols)) begin
      d.status = brag_pkg::STATUS_COL_RANGE;
      expected_descs.push_back(d);
    end else begin
      row_len = brag_pkg::ROW_LEN_W'(64'(shadow_cfg.block_cols) * eb);
      for (logic [63:0] r = 0; r < nrows; r++) begin
        offset = (64'(shadow_cfg.matrix_cols) * (row0 + r) + col0) * eb;
        d.rank        = shadow_cfg.rank_number;
        d.first_addr  = req.first_base + offset;
        d.second_addr = req.second_base + offset;
        d.row_len     = row_len;
        d.last        = (r + 1 == nrows);
        d.status      = brag_pkg::STATUS_OK;
        expected_descs.push_back(d);
      end
    end
  endfunction

  function automatic void check_field(input string name, input logic [63:0] exp_val,
                                      input logic [63:0] act_val);
    if (act_val !== exp_val) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_val, act_val);
      errors++;
    end
  endfunction

  function automatic block_req_t make_req(input logic [15:0] brow, input logic [15:0] bcol,
                                          input logic [63:0] a, input logic [63:0] b);
    block_req_t q;
    q.brow        = brow;
    q.bcol        = bcol;
    q.first_base  = a;
    q.second_base = b;
    return q;
  endfunction

  // mostly requests that land inside the matrix, the rest anywhere
  function automatic block_req_t random_req(input bit fit);
    block_req_t  q;
    int unsigned nrows;
    int unsigned brow_max;
    int unsigned bcol_max;
    nrows = (shadow_cfg.block_rows > brag_pkg::MAX_BLOCK_ROWS_DEF) ?
            brag_pkg::MAX_BLOCK_ROWS_DEF : shadow_cfg.block_rows;
    q.brow        = 16'($urandom);
    q.bcol        = 16'($urandom);
    q.first_base  = {$urandom, $urandom};
    q.second_base = {$urandom, $urandom};
    if ($urandom_range(7, 0) == 0) q.first_base = ~64'($urandom_range(4095, 0));
    if ($urandom_range(7, 0) == 0) q.second_base = ~64'($urandom_range(4095, 0));
    if (fit && shadow_cfg.matrix_rows != 0 && shadow_cfg.matrix_cols != 0) begin
      brow_max = (nrows == 0) ? 65535 : (shadow_cfg.matrix_rows - 1) / nrows;
      bcol_max = (shadow_cfg.block_cols == 0) ? 65535
                                              : (shadow_cfg.matrix_cols - 1) / shadow_cfg.block_cols;
      q.brow = ($urandom_range(3, 0) == 0) ? 16'(brow_max) : 16'($urandom_range(brow_max, 0));
      q.bcol = ($urandom_range(3, 0) == 0) ? 16'(bcol_max) : 16'($urandom_range(bcol_max, 0));
    end
    return q;
  endfunction

  function automatic brag_pkg::cfg_t random_cfg();
    brag_pkg::cfg_t c;
    c.matrix_rows = ($urandom_range(3, 0) == 0) ? 16'($urandom_range(65535, 1))
                                                : 16'($urandom_range(300, 1));
    c.matrix_cols = ($urandom_range(3, 0) == 0) ? 16'($urandom_range(65535, 1))
                                                : 16'($urandom_range(300, 1));
    c.block_rows = ($urandom_range(9, 0) == 0) ? 7'($urandom_range(127, 64))
                                               : 7'($urandom_range(8, 1));
    case ($urandom_range(3, 0))
      0: c.block_cols = 16'hffff;
      1: c.block_cols = 16'($urandom_range(65535, 1));
      default: c.block_cols = 16'($urandom_range(16, 1));
    endcase
    c.rank_number   = 16'($urandom);
    c.element_bytes = 4'($urandom_range(15, 0));
    return c;
  endfunction

  // leaves the write enable high, the caller lowers it after the last write
  task automatic write_reg(input logic [brag_pkg::CFG_IDX_W-1:0] idx,
                           input logic [brag_pkg::CFG_DATA_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    case (idx)
      brag_pkg::CFG_MATRIX_ROWS:   shadow_cfg.matrix_rows   = data;
      brag_pkg::CFG_MATRIX_COLS:   shadow_cfg.matrix_cols   = data;
      brag_pkg::CFG_BLOCK_ROWS:    shadow_cfg.block_rows    = data[6:0];
      brag_pkg::CFG_BLOCK_COLS:    shadow_cfg.block_cols    = data;
      brag_pkg::CFG_RANK_NUMBER:   shadow_cfg.rank_number   = data;
      brag_pkg::CFG_ELEMENT_BYTES: shadow_cfg.element_bytes = data[3:0];
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  task automatic set_regs(input brag_pkg::cfg_t c);
    write_reg(brag_pkg::CFG_MATRIX_ROWS, c.matrix_rows);
    write_reg(brag_pkg::CFG_MATRIX_COLS, c.matrix_cols);
    write_reg(brag_pkg::CFG_BLOCK_ROWS, 16'(c.block_rows));
    write_reg(brag_pkg::CFG_BLOCK_COLS, c.block_cols);
    write_reg(brag_pkg::CFG_RANK_NUMBER, c.rank_number);
    write_reg(brag_pkg::CFG_ELEMENT_BYTES, 16'(c.element_bytes));
    cfg_we_i <= 1'b0;
  endtask

  // called at a falling edge, returns at the falling edge after the transaction
  task automatic send_req(input block_req_t req);
    while (!no_idle && $urandom_range(99, 0) < IDLE_PCT) begin
      req_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_ch.valid           <= 1'b1;
    req_ch.block_row_index <= req.brow;
    req_ch.block_col_index <= req.bcol;
    req_ch.first_base      <= req.first_base;
    req_ch.second_base     <= req.second_base;
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
    predict_rows(req);
    @(negedge clk_i);
  endtask

  // requests with no descriptor may still be in work once the queue is empty
  task automatic wait_idle();
    req_ch.valid <= 1'b0;
    while (expected_descs.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic test_defaults();
    send_req(make_req(16'd0, 16'd0, 64'd0, 64'd0));
    send_req(make_req(16'd0, 16'd0, '1, 64'h8000_0000_0000_0000));
    send_req(make_req(16'd1, 16'd0, 64'h1234, 64'h5678));
    send_req(make_req(16'd0, 16'd1, 64'h1234, 64'h5678));
    send_req(make_req(16'hffff, 16'hffff, '1, '1));
  endtask

  task automatic test_shape_limits();
    wait_idle();
    // empty matrix: every request fails the row test
    set_regs('{matrix_rows: 16'd0, matrix_cols: 16'hffff, block_rows: 7'd1,
               block_cols: 16'd1, rank_number: 16'hffff, element_bytes: 4'd8});
    send_req(make_req(16'd0, 16'd0, 64'h100, 64'h200));
    wait_idle();
    // largest shape, oversized block rows and element size saturate
    set_regs('{matrix_rows: 16'hffff, matrix_cols: 16'hffff, block_rows: 7'd127,
               block_cols: 16'hffff, rank_number: 16'hffff, element_bytes: 4'd15});
    send_req(make_req(16'd0, 16'd0, '1, 64'hffff_ffff_ffff_fff0));
    // last block rows run past the bottom of the matrix
    send_req(make_req(16'd1023, 16'd0, {$urandom, $urandom}, {$urandom, $urandom}));
    send_req(make_req(16'd1024, 16'd0, 64'd0, 64'd0));
    send_req(make_req(16'd0, 16'd1, 64'd0, 64'd0));
  endtask

  task automatic test_zero_cases();
    wait_idle();
    // no block rows: nothing unless the column test fails
    set_regs('{matrix_rows: 16'd8, matrix_cols: 16'd8, block_rows: 7'd0,
               block_cols: 16'd2, rank_number: 16'd5, element_bytes: 4'd3});
    send_req(make_req(16'd0, 16'd0, 64'h40, 64'h80));
    send_req(make_req(16'd0, 16'd4, 64'h40, 64'h80));
    send_req(make_req(16'd0, 16'd3, 64'h40, 64'h80));
    wait_idle();
    // zero-byte elements give zero offsets and zero row length
    set_regs('{matrix_rows: 16'd8, matrix_cols: 16'd8, block_rows: 7'd3,
               block_cols: 16'd2, rank_number: 16'ha5a5, element_bytes: 4'd0});
    send_req(make_req(16'd1, 16'd2, 64'h1000, 64'h2000));
  endtask

  task automatic test_unknown_index();
    wait_idle();
    // upper data bits are dropped, spare indexes change nothing
    write_reg(brag_pkg::CFG_BLOCK_ROWS, 16'hff83);
    write_reg(brag_pkg::CFG_ELEMENT_BYTES, 16'hfff7);
    write_reg(CFG_SPARE_A, 16'hffff);
    write_reg(CFG_SPARE_B, 16'h0000);
    cfg_we_i <= 1'b0;
    send_req(make_req(16'd1, 16'd1, 64'h10, 64'h20));
    send_req(make_req(16'd2, 16'd3, 64'h30, 64'h40));
  endtask

  task automatic test_backpressure();
    wait_idle();
    set_regs('{matrix_rows: 16'd200, matrix_cols: 16'd100, block_rows: 7'd16,
               block_cols: 16'd4, rank_number: 16'd7, element_bytes: 4'd4});
    hold_requests++;
    for (int unsigned i = 0; i < 8; i++) send_req(random_req(1'b1));
  endtask

  task automatic test_random();
    for (int unsigned ph = 0; ph < 12; ph++) begin
      wait_idle();
      no_idle = (ph == 4);
      set_regs(random_cfg());
      for (int unsigned i = 0; i < 34; i++) send_req(random_req($urandom_range(99, 0) < 80));
    end
    no_idle = 1'b0;
  endtask

  // descriptor sink with random stalls and the requested long hold-off
  initial begin : desc_ready
    int unsigned hold_left;
    int unsigned holds_served;
    hold_left    = 0;
    holds_served = 0;
    desc_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (holds_served != hold_requests) begin
        hold_left    = HOLD_CYCLES;
        holds_served = hold_requests;
      end
      if (hold_left != 0) begin
        desc_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        desc_ch.ready <= no_idle || ($urandom_range(99, 0) >= IDLE_PCT);
      end
    end
  end

  always @(posedge clk_i) begin : desc_check
    row_desc_t oldest;
    if (rst_ni && desc_ch.valid && desc_ch.ready) begin
      if (expected_descs.size() == 0) begin
        $display("%0t: descriptor transaction with none expected, expected none, actual %0h",
                 $time, desc_ch.first_address);
        errors++;
      end else begin
        oldest = expected_descs.pop_front();
        check_field("rank_out", 64'(oldest.rank), 64'(desc_ch.rank_out));
        check_field("first_address", oldest.first_addr, desc_ch.first_address);
        check_field("second_address", oldest.second_addr, desc_ch.second_address);
        check_field("row_length_bytes", 64'(oldest.row_len), 64'(desc_ch.row_length_bytes));
        check_field("last_row", 64'(oldest.last), 64'(desc_ch.last_row));
        check_field("status", 64'(oldest.status), 64'(desc_ch.status));
      end
    end
  end

  initial begin : watchdog
    int unsigned stuck;
    stuck = 0;
    while (stuck < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((req_ch.valid && req_ch.ready) || (desc_ch.valid && desc_ch.ready)) stuck = 0;
      else stuck++;
    end
    $display("status: fail");
    $finish;
  end

  initial begin : run
    errors        = 0;
    no_idle       = 1'b0;
    hold_requests = 0;
    shadow_cfg    = '{matrix_rows: 16'd1, matrix_cols: 16'd1, block_rows: 7'd1,
                      block_cols: 16'd1, rank_number: 16'd0, element_bytes: 4'd1};
    rst_ni                 = 1'b0;
    cfg_we_i               = 1'b0;
    cfg_idx_i              = brag_pkg::CFG_MATRIX_ROWS;
    cfg_data_i             = '0;
    req_ch.valid           = 1'b0;
    req_ch.block_row_index = '0;
    req_ch.block_col_index = '0;
    req_ch.first_base      = '0;
    req_ch.second_base     = '0;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_defaults();
    test_shape_limits();
    test_zero_cases();
    test_unknown_index();
    test_backpressure();
    test_random();
    wait_idle();
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
